@@ sv/multi_channel_edge_debouncer_macros.svh @@
// Assertion macros for the multi-channel edge debouncer.
// Included by the top level, lane and merge modules; no other dependencies.
`ifndef MULTI_CHANNEL_EDGE_DEBOUNCER_MACROS_SVH
`define MULTI_CHANNEL_EDGE_DEBOUNCER_MACROS_SVH

`ifndef SYNTHESIS
`define MCED_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MCED_ASSERT_COMB(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`else
`define MCED_ASSERT(lbl, clk, rstn, prop, msg)
`define MCED_ASSERT_COMB(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ sv/mced_pkg.sv @@
// Shared types and constants for the multi-channel edge debouncer.
// No dependencies.
package mced_pkg;

	localparam int CHANNELS        = 17;
	localparam int FIELD_W         = 17;
	localparam int CNT_W           = 8;
	localparam int LANES           = (CHANNELS < FIELD_W) ? CHANNELS : FIELD_W;
	localparam int IN_DATA_W       = ((FIELD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W      = ((3 * FIELD_W + 7) / 8) * 8;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CNT_W-1:0] DEFAULT_LOCKOUT = CNT_W'(40);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE      = 2'd0,
		REG_PUSHBUTTON  = 2'd1,
		REG_ACTIVE_HIGH = 2'd2,
		REG_LOCKOUT     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic enable;
		logic pushbutton;
		logic active_high;
	} lane_cfg_t;

	typedef struct packed {
		logic pressed;
		logic active;
		logic inactive;
	} lane_evt_t;

endpackage

@@ sv/multi_channel_edge_debouncer.sv @@
// Top level of the multi-channel edge debouncer: config registers, lanes, merge stage.
// Depends on mced_pkg, mced_lane, mced_merge and the assertion macro header.
//
//  port group   dir  fields (lsb first)
//  s_*          in   tdata: pin_levels[16:0]; tuser: tick
//  m_*          out  tdata: pressed_mask[16:0], active_mask[33:17], inactive_mask[50:34]
//  cfg_*        in   index 0 enable, 1 pushbutton, 2 active_high, 3 lockout_ticks
//
// One word per cycle while s_tready is high; each word's result is registered on
// acceptance. The two-word output skid lets input run on while a result waits;
// s_tready drops only when both output slots are full.
// Reset: all channels disabled, pin history all ones, lockout 40 ticks.
`include "multi_channel_edge_debouncer_macros.svh"

module multi_channel_edge_debouncer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mced_pkg::IN_DATA_W-1:0]        s_tdata,   // pin_levels
	input  logic                                  s_tuser,   // tick
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mced_pkg::OUT_DATA_W-1:0]       m_tdata,   // pressed, active, inactive
	input  logic                                  cfg_we,
	input  logic [mced_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mced_pkg::FIELD_W-1:0]          cfg_wdata
);
	import mced_pkg::*;

	logic [FIELD_W-1:0] enable_q, pushbutton_q, active_high_q;
	logic [CNT_W-1:0]   lockout_q;
	logic [CNT_W-1:0]   load;
	logic               fire;
	lane_evt_t [LANES-1:0] evt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= '0;
			pushbutton_q  <= '0;
			active_high_q <= '0;
			lockout_q     <= DEFAULT_LOCKOUT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE:      enable_q      <= cfg_wdata;
				REG_PUSHBUTTON:  pushbutton_q  <= cfg_wdata;
				REG_ACTIVE_HIGH: active_high_q <= cfg_wdata;
				REG_LOCKOUT:     lockout_q     <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero lockout behaves as one tick
	assign load = (lockout_q == '0) ? CNT_W'(1) : lockout_q;
	assign fire = s_tvalid & s_tready;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		lane_cfg_t lane_cfg;
		assign lane_cfg.enable      = enable_q[i];
		assign lane_cfg.pushbutton  = pushbutton_q[i];
		assign lane_cfg.active_high = active_high_q[i];

		mced_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.fire   (fire),
			.level  (s_tdata[i]),
			.tick   (s_tuser),
			.cfg    (lane_cfg),
			.load   (load),
			.evt    (evt[i])
		);
	end

	mced_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.evt      (evt),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ sv/mced_lane.sv @@
// One debounce lane: edge detect, lockout counter and expiry judgement for one channel.
// Depends on mced_pkg and the assertion macro header.
`include "multi_channel_edge_debouncer_macros.svh"

module mced_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic                      level,
	input  logic                      tick,
	input  mced_pkg::lane_cfg_t       cfg,
	input  logic [mced_pkg::CNT_W-1:0] load,
	output mced_pkg::lane_evt_t       evt
);
	import mced_pkg::*;

	logic             prev_q;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;

	logic busy_eff, counting, expire, busy_after, at_active, edge_hit;

	always_comb begin
		busy_eff     = busy_q & cfg.enable;
		counting     = tick & busy_eff & (cnt_q > CNT_W'(1));
		expire       = tick & busy_eff & ~(cnt_q > CNT_W'(1));
		busy_after   = busy_eff & ~expire;
		at_active    = (level == cfg.active_high);
		evt.pressed  = expire & cfg.pushbutton & at_active;
		evt.active   = expire & ~cfg.pushbutton & at_active;
		evt.inactive = expire & ~cfg.pushbutton & ~at_active;
		edge_hit     = cfg.enable & ~busy_after &
			(cfg.pushbutton ? (prev_q & ~level) : (prev_q ^ level));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (fire) begin
			prev_q <= level;
			busy_q <= busy_after | edge_hit;
			if (edge_hit) begin
				cnt_q <= load;
			end else if (counting) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`MCED_ASSERT_COMB(a_evt_onehot, clk, arst_n, $onehot0({evt.pressed, evt.active, evt.inactive}), "lane reports more than one event")
	`MCED_ASSERT(a_evt_needs_busy, clk, arst_n, (evt.pressed | evt.active | evt.inactive) |-> (busy_q && tick && cfg.enable), "event without running lockout")
	`MCED_ASSERT(a_disable_drops, clk, arst_n, (fire && !cfg.enable) |=> !busy_q, "disabled lane still counting")

endmodule

@@ sv/mced_merge.sv @@
// Merge stage: gathers lane events into three masks and holds the word in a skid buffer.
// Depends on mced_pkg and the assertion macro header.
`include "multi_channel_edge_debouncer_macros.svh"

module mced_merge (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     fire,
	input  mced_pkg::lane_evt_t [mced_pkg::LANES-1:0] evt,
	output logic                                     in_ready,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [mced_pkg::OUT_DATA_W-1:0]          m_tdata
);
	import mced_pkg::*;

	logic [FIELD_W-1:0]    pressed, active, inactive;
	logic [OUT_DATA_W-1:0] word;
	logic [OUT_DATA_W-1:0] out_q, skid_q;
	logic                  out_valid_q, skid_valid_q;
	logic                  take;

	always_comb begin
		pressed  = '0;
		active   = '0;
		inactive = '0;
		for (int i = 0; i < LANES; i++) begin
			pressed[i]  = evt[i].pressed;
			active[i]   = evt[i].active;
			inactive[i] = evt[i].inactive;
		end
		word = OUT_DATA_W'({inactive, active, pressed});
	end

	assign take     = out_valid_q & m_tready;
	assign in_ready = ~skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= fire;
			end
		end else if (fire) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_valid_q ? skid_q : word;
		end else if (fire) begin
			if (out_valid_q) begin
				skid_q <= word;
			end else begin
				out_q <= word;
			end
		end
	end

	`MCED_ASSERT_COMB(a_skid_implies_out, clk, arst_n, !skid_valid_q || out_valid_q, "skid word without output word")
	`MCED_ASSERT(a_stall_to_skid, clk, arst_n, (fire && out_valid_q && !m_tready) |=> skid_valid_q, "stalled word not parked")
	`MCED_ASSERT(a_skid_drains, clk, arst_n, (skid_valid_q && m_tready) |=> (out_valid_q && !skid_valid_q), "skid word not moved forward")

endmodule
